@@ design/udfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udfc_pkg: shared definitions for the update frame deframer
// header codes, frame positions, result beat type and the crc16 byte update
// ----------------------------------------------------------------------------
package udfc_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int POS_W       = 11;

  localparam logic [7:0]  HDR_FIRST  = 8'h55;
  localparam logic [7:0]  HDR_SECOND = 8'hAA;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam logic [POS_W-1:0] FRAME_OVERHEAD = POS_W'(13);
  localparam logic [POS_W-1:0] CRC_TRAIL      = POS_W'(2);
  localparam logic [15:0]      MAX_LEN        = 16'(MAX_PAYLOAD);

  // positions in the frame, counted from the first header byte
  localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_OFS_0   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_OFS_1   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_OFS_2   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_OFS_3   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(11);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [31:0] image_offset;
    logic [10:0] payload_length;
    logic        crc_match;
  } result_t;

  // reflected crc16, one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ design/udfc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udfc_parser: frame position tracker, header capture and running crc16
// one byte per accepted beat, result formed in the same cycle
// ----------------------------------------------------------------------------
module udfc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output udfc_pkg::result_t res
);
  import udfc_pkg::*;

  logic [POS_W-1:0] frame_pos, frame_pos_next;
  logic [POS_W-1:0] expected_len, expected_len_next;
  logic [7:0]       cmd_reg, cmd_reg_next;
  logic [15:0]      seq_reg, seq_reg_next;
  logic [31:0]      offset_reg, offset_reg_next;
  logic [10:0]      len_reg, len_reg_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       crc_low_hold, crc_low_hold_next;

  logic [15:0]      full_len;
  logic [POS_W-1:0] crc_lo_pos;
  logic [POS_W-1:0] data_idx;

  assign full_len   = {rx_byte, len_reg[7:0]};
  assign crc_lo_pos = expected_len - CRC_TRAIL;
  assign data_idx   = frame_pos - POS_PAYLOAD;

  always_comb begin
    frame_pos_next    = frame_pos;
    expected_len_next = expected_len;
    cmd_reg_next      = cmd_reg;
    seq_reg_next      = seq_reg;
    offset_reg_next   = offset_reg;
    len_reg_next      = len_reg;
    running_crc_next  = running_crc;
    crc_low_hold_next = crc_low_hold;
    res_valid         = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = rx_byte;
    res.byte_index     = data_idx[9:0];
    res.command        = cmd_reg;
    res.sequence_res   = seq_reg;
    res.image_offset   = offset_reg;
    res.payload_length = len_reg;
    res.crc_match      = 1'b0;

    if (frame_pos == POS_HUNT) begin
      if (rx_byte == HDR_FIRST) frame_pos_next = POS_HDR2;
    end else if (frame_pos == POS_HDR2) begin
      if (rx_byte == HDR_SECOND)     frame_pos_next = POS_CMD;
      else if (rx_byte == HDR_FIRST) frame_pos_next = POS_HDR2;
      else                           frame_pos_next = POS_HUNT;
    end else begin
      frame_pos_next = frame_pos + POS_W'(1);
      if (frame_pos < POS_PAYLOAD) begin
        running_crc_next = crc_byte((frame_pos == POS_CMD) ? CRC_INIT : running_crc, rx_byte);
        unique case (frame_pos)
          POS_CMD:    cmd_reg_next = rx_byte;
          POS_SEQ_LO: seq_reg_next = {8'h00, rx_byte};
          POS_SEQ_HI: seq_reg_next = {rx_byte, seq_reg[7:0]};
          POS_OFS_0:  offset_reg_next = {24'h0, rx_byte};
          POS_OFS_1:  offset_reg_next = {16'h0, rx_byte, offset_reg[7:0]};
          POS_OFS_2:  offset_reg_next = {8'h0, rx_byte, offset_reg[15:0]};
          POS_OFS_3:  offset_reg_next = {rx_byte, offset_reg[23:0]};
          POS_LEN_LO: len_reg_next = {3'b000, rx_byte};
          default: begin
            // length high byte: oversized frames are dropped silently
            if (full_len > MAX_LEN) begin
              frame_pos_next    = POS_HUNT;
              expected_len_next = POS_W'(0);
            end else begin
              len_reg_next      = full_len[10:0];
              expected_len_next = FRAME_OVERHEAD + full_len[POS_W-1:0];
            end
          end
        endcase
      end else if (frame_pos < crc_lo_pos) begin
        running_crc_next = crc_byte(running_crc, rx_byte);
        res_valid        = 1'b1;
      end else if (frame_pos == crc_lo_pos) begin
        crc_low_hold_next = rx_byte;
      end else begin
        res_valid          = 1'b1;
        res.kind           = KIND_DONE;
        res.data_byte      = 8'h00;
        res.byte_index     = 10'd0;
        res.crc_match      = ({rx_byte, crc_low_hold} == running_crc);
        frame_pos_next     = POS_HUNT;
        expected_len_next  = POS_W'(0);
      end
    end

    if (!accept) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos    <= POS_HUNT;
      expected_len <= '0;
      cmd_reg      <= '0;
      seq_reg      <= '0;
      offset_reg   <= '0;
      len_reg      <= '0;
      running_crc  <= CRC_INIT;
      crc_low_hold <= '0;
    end else if (accept) begin
      frame_pos    <= frame_pos_next;
      expected_len <= expected_len_next;
      cmd_reg      <= cmd_reg_next;
      seq_reg      <= seq_reg_next;
      offset_reg   <= offset_reg_next;
      len_reg      <= len_reg_next;
      running_crc  <= running_crc_next;
      crc_low_hold <= crc_low_hold_next;
    end
  end

endmodule

@@ design/update_frame_deframer_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_frame_deframer_crc16: byte stream deframer with crc16 check
// hunts for the 55 aa header, emits payload beats and a frame summary beat
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_ready  | rx_byte
//  out     | output    | out_valid / out_ready| kind, data_byte, byte_index,
//          |           |                      | command, sequence_res,
//          |           |                      | image_offset, payload_length,
//          |           |                      | crc_match
//
//  one byte beat per cycle while in_ready is high; each result is registered
//  in the output register, or first in the skid entry when the output is stalled
//  the parser state and crc update together on each accepted byte, so the loop through
//  the frame position counter and crc register sets the one-beat rate
//  an output register plus a one-entry skid buffer: input stalls only when
//  both hold results
//  synchronous reset returns to hunting with crc at ffff, output empty
module update_frame_deframer_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [9:0]  byte_index,
  output logic [7:0]  command,
  output logic [15:0] sequence_res,
  output logic [31:0] image_offset,
  output logic [10:0] payload_length,
  output logic        crc_match
);
  import udfc_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;

  // output register and skid entry
  logic    out_full;
  result_t out_data;
  logic    skid_full;
  result_t skid_data;

  logic    pop;
  logic    push;

  assign in_ready = !skid_full;
  assign accept   = in_valid && in_ready;
  assign pop      = out_full && out_ready;
  assign push     = res_valid;

  udfc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      // no new beat can arrive while the skid is occupied
      if (pop) begin
        out_data  <= skid_data;
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_full || pop) begin
        out_data <= res;
        out_full <= 1'b1;
      end else begin
        skid_data <= res;
        skid_full <= 1'b1;
      end
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid      = out_full;
  assign kind           = out_data.kind;
  assign data_byte      = out_data.data_byte;
  assign byte_index     = out_data.byte_index;
  assign command        = out_data.command;
  assign sequence_res   = out_data.sequence_res;
  assign image_offset   = out_data.image_offset;
  assign payload_length = out_data.payload_length;
  assign crc_match      = out_data.crc_match;

endmodule
